// ===== design/feedback_bus_scan_change_events_macros.svh =====
// assertion macros shared by the feedback bus scanner rtl
// depends on clk and rst_n being visible where a macro is used
`ifndef FEEDBACK_BUS_SCAN_CHANGE_EVENTS_MACROS_SVH
`define FEEDBACK_BUS_SCAN_CHANGE_EVENTS_MACROS_SVH

// same-cycle property, checked outside reset
`define FBSCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition this cycle implies a property on the next cycle
`define FBSCE_ASSERT_STEP(label, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== design/fbsce_pkg.sv =====
// shared constants and types for the feedback bus scanner
// no dependencies
`default_nettype none

package fbsce_pkg;

    localparam int MAX_MODULES         = 32;
    localparam int CONTACTS_PER_MODULE = 16;
    localparam int NUM_CONTACTS        = MAX_MODULES * CONTACTS_PER_MODULE;
    localparam int CONTACT_AW          = $clog2(NUM_CONTACTS);
    localparam int NBITS_W             = $clog2(NUM_CONTACTS + 1);
    localparam int CPM_SHIFT           = $clog2(CONTACTS_PER_MODULE);
    localparam int MOD_EFF_W           = $clog2(MAX_MODULES + 1);
    localparam int GAP_W               = $clog2(MAX_MODULES + 2);
    localparam int TICK_W              = 27;

    localparam int MODULE_W  = 6;
    localparam int OFFSET_W  = 10;
    localparam int UNIT_W    = 16;
    localparam int CFG_DW    = 16;
    localparam int CFG_AW    = 2;
    localparam int ID_W      = 32;
    localparam int NUM_W     = 15;

    localparam logic [ID_W-1:0]     EVENT_ID_BASE = 32'h80220B01;
    localparam logic [MODULE_W-1:0] MODULE_RESET  = 6'd1;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 10'd0;
    localparam logic [UNIT_W-1:0]   UNIT_RESET    = 16'd100;
    localparam logic [UNIT_W-1:0]   UNIT_MIN      = 16'd2;

    localparam logic [CFG_AW-1:0] CFG_MODULE_COUNT  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SENSOR_OFFSET = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_UNIT_TICKS    = 2'd2;

    typedef struct packed {
        logic                  en;
        logic [CONTACT_AW-1:0] addr;
        logic                  data;
    } contact_wr_t;

endpackage

`default_nettype wire

// ===== design/fbsce_contact_store.sv =====
// contact level memory with a clearing pass after reset and registered read
// depends on fbsce_pkg and the shared assertion macros
`default_nettype none
`include "feedback_bus_scan_change_events_macros.svh"

module fbsce_contact_store
    import fbsce_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire contact_wr_t           wr,
    input  wire logic [CONTACT_AW-1:0] rd_addr,
    output logic                       rd_data,
    output logic                       ready
);

    logic                  mem [NUM_CONTACTS];
    logic                  clear_reg;
    logic [CONTACT_AW-1:0] clear_addr_reg;
    logic                  rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == CONTACT_AW'(NUM_CONTACTS - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clear_addr_reg] <= 1'b0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clear_reg;

    `FBSCE_ASSERT(a_no_write_in_clear, !(wr.en && clear_reg), "contact write during clear")
    `FBSCE_ASSERT_STEP(a_clear_advances, clear_reg && clear_addr_reg != CONTACT_AW'(NUM_CONTACTS - 1), clear_reg && clear_addr_reg == CONTACT_AW'($past(clear_addr_reg) + 1'b1), "clear pass skipped an entry")
    `FBSCE_ASSERT_STEP(a_clear_stays_done, !clear_reg, !clear_reg, "clear pass restarted")

endmodule

`default_nettype wire

// ===== design/feedback_bus_scan_change_events.sv =====
// Feedback bus scanner: one input word is one tick of the bus sequencer, and every
// accepted word gives exactly one output word with the load, clock and reset line
// levels for that tick plus an optional contact change event. One word is taken per
// clock cycle while in_ready is high, and each result is registered. A skid register
// behind the output register takes one more word when the output stalls, after which
// in_ready drops until the output moves again.
// After reset the 512-entry contact memory is cleared one entry per cycle, so
// in_ready stays low until the clearing is done. Configuration writes are taken at
// any time but are meant for idle periods.
// depends on fbsce_pkg, fbsce_contact_store and the shared assertion macros
`default_nettype none
`include "feedback_bus_scan_change_events_macros.svh"

module feedback_bus_scan_change_events
    import fbsce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [CFG_AW-1:0]   cfg_index,
    input  wire logic [CFG_DW-1:0]   cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                data_level,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     load_line,
    output logic                     clock_line,
    output logic                     reset_line,
    output logic                     event_valid,
    output logic [ID_W-1:0]          event_id,
    output logic [NUM_W-1:0]         contact_number,
    output logic                     contact_value
);

    typedef enum logic [2:0] {
        PH_LOAD,
        PH_CLK_HI,
        PH_CLK_LO,
        PH_RST_HI,
        PH_RST_LO,
        PH_BIT_LOW,
        PH_BIT_CLK,
        PH_GAP
    } phase_t;

    typedef struct packed {
        logic             load_line;
        logic             clock_line;
        logic             reset_line;
        logic             event_valid;
        logic [ID_W-1:0]  event_id;
        logic [NUM_W-1:0] contact_number;
        logic             contact_value;
    } result_t;

    logic [MODULE_W-1:0] module_count_reg;
    logic [OFFSET_W-1:0] sensor_offset_reg;
    logic [UNIT_W-1:0]   unit_ticks_reg;

    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     ticks_reg, ticks_next;
    logic [CONTACT_AW-1:0] bit_pos_reg, bit_pos_next;

    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic                  store_ready;
    logic                  stored_level;
    contact_wr_t           wr;
    logic                  in_fire;

    logic [UNIT_W-1:0]     unit_eff;
    logic [UNIT_W-2:0]     half;
    logic [MOD_EFF_W-1:0]  mod_eff;
    logic [NBITS_W-1:0]    nbits;
    logic [NBITS_W-1:0]    bit_pos_inc;
    logic [GAP_W-1:0]      gap_units;
    logic [GAP_W+UNIT_W-1:0] gap_prod;
    logic [TICK_W-1:0]     phase_len;
    logic [TICK_W-1:0]     ticks_inc;
    logic                  sample;
    logic                  change;

    fbsce_contact_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (bit_pos_reg),
        .rd_data (stored_level),
        .ready   (store_ready)
    );

    assign in_ready = store_ready && !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    // effective register values
    always_comb
    begin
        unit_eff    = (unit_ticks_reg < UNIT_MIN) ? UNIT_MIN : unit_ticks_reg;
        half        = unit_eff[UNIT_W-1:1];
        mod_eff     = (MOD_EFF_W'(module_count_reg) > MOD_EFF_W'(MAX_MODULES))
                      ? MOD_EFF_W'(MAX_MODULES) : MOD_EFF_W'(module_count_reg);
        nbits       = NBITS_W'(mod_eff) << CPM_SHIFT;
        gap_units   = GAP_W'(MAX_MODULES + 1) - GAP_W'(mod_eff);
        gap_prod    = gap_units * unit_eff;
        bit_pos_inc = NBITS_W'(bit_pos_reg) + 1'b1;
        ticks_inc   = ticks_reg + 1'b1;
    end

    // tick evaluation
    always_comb
    begin
        res_next = '0;
        unique case (phase_reg)
            PH_LOAD, PH_CLK_LO, PH_RST_LO:
            begin
                res_next.load_line = 1'b1;
            end
            PH_CLK_HI:
            begin
                res_next.load_line  = 1'b1;
                res_next.clock_line = 1'b1;
            end
            PH_RST_HI:
            begin
                res_next.load_line  = 1'b1;
                res_next.reset_line = 1'b1;
            end
            PH_BIT_CLK:
            begin
                res_next.clock_line = 1'b1;
            end
            default:
            begin
            end
        endcase

        sample = (phase_reg == PH_BIT_LOW) && (ticks_reg == TICK_W'(half));
        change = sample && (stored_level != data_level);
        if (change)
        begin
            res_next.event_valid    = 1'b1;
            res_next.event_id       = EVENT_ID_BASE + ID_W'(sensor_offset_reg);
            res_next.contact_number = (NUM_W'(sensor_offset_reg) << CPM_SHIFT)
                                      + NUM_W'(bit_pos_reg) + 1'b1;
            res_next.contact_value  = data_level;
        end

        wr.en   = in_fire && change;
        wr.addr = bit_pos_reg;
        wr.data = data_level;

        unique case (phase_reg)
            PH_BIT_LOW: phase_len = TICK_W'({half, 1'b0});
            PH_GAP:     phase_len = TICK_W'(gap_prod) << CPM_SHIFT;
            default:    phase_len = TICK_W'(unit_eff);
        endcase

        phase_next   = phase_reg;
        bit_pos_next = bit_pos_reg;
        ticks_next   = ticks_inc;
        if (ticks_inc >= phase_len)
        begin
            ticks_next = '0;
            unique case (phase_reg)
                PH_LOAD:    phase_next = PH_CLK_HI;
                PH_CLK_HI:  phase_next = PH_CLK_LO;
                PH_CLK_LO:  phase_next = PH_RST_HI;
                PH_RST_HI:  phase_next = PH_RST_LO;
                PH_RST_LO:
                begin
                    bit_pos_next = '0;
                    phase_next   = (nbits != '0) ? PH_BIT_LOW : PH_GAP;
                end
                PH_BIT_LOW: phase_next = PH_BIT_CLK;
                PH_BIT_CLK:
                begin
                    if (bit_pos_inc < nbits)
                    begin
                        bit_pos_next = bit_pos_inc[CONTACT_AW-1:0];
                        phase_next   = PH_BIT_LOW;
                    end
                    else
                    begin
                        bit_pos_next = '0;
                        phase_next   = PH_GAP;
                    end
                end
                PH_GAP:     phase_next = PH_LOAD;
                default:    phase_next = PH_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_count_reg  <= MODULE_RESET;
            sensor_offset_reg <= OFFSET_RESET;
            unit_ticks_reg    <= UNIT_RESET;
            phase_reg         <= PH_LOAD;
            ticks_reg         <= '0;
            bit_pos_reg       <= '0;
            out_reg           <= '0;
            skid_reg          <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_MODULE_COUNT:  module_count_reg  <= cfg_data[MODULE_W-1:0];
                    CFG_SENSOR_OFFSET: sensor_offset_reg <= cfg_data[OFFSET_W-1:0];
                    CFG_UNIT_TICKS:    unit_ticks_reg    <= cfg_data[UNIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_fire)
            begin
                phase_reg   <= phase_next;
                ticks_reg   <= ticks_next;
                bit_pos_reg <= bit_pos_next;
            end

            // main output word plus skid word
            if (out_valid_reg && out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else if (in_fire)
                begin
                    out_reg <= res_next;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (!out_valid_reg)
            begin
                if (in_fire)
                begin
                    out_reg       <= res_next;
                    out_valid_reg <= 1'b1;
                end
            end
            else if (in_fire)
            begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign load_line      = out_reg.load_line;
    assign clock_line     = out_reg.clock_line;
    assign reset_line     = out_reg.reset_line;
    assign event_valid    = out_reg.event_valid;
    assign event_id       = out_reg.event_id;
    assign contact_number = out_reg.contact_number;
    assign contact_value  = out_reg.contact_value;

    `FBSCE_ASSERT(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid word without main word")
    `FBSCE_ASSERT(a_no_accept_in_clear, store_ready || !in_ready, "input taken during memory clear")
    `FBSCE_ASSERT(a_event_lines_low, !(out_valid_reg && out_reg.event_valid) || (!out_reg.load_line && !out_reg.clock_line && !out_reg.reset_line), "event word with a bus line driven")
    `FBSCE_ASSERT_STEP(a_hold_without_tick, !in_fire, $stable(phase_reg) && $stable(ticks_reg) && $stable(bit_pos_reg), "sequencer moved without a tick")

endmodule

`default_nettype wire
